FILE: src/wolp_pkg.sv
`timescale 1ns / 1ps

package wolp_pkg;

   // field widths
   localparam int unsigned TotalWidth  = 32;
   localparam int unsigned ScaleWidth  = 30;
   localparam int unsigned PhaseWidth  = 3;
   localparam int unsigned TenthsWidth = 16;
   localparam int unsigned IndexWidth  = 2;
   localparam int unsigned Q20Shift    = 20;
   // rounded Q20 result of a 32-bit product
   localparam int unsigned WheelWidth  = TotalWidth - Q20Shift;

   localparam logic [TotalWidth-1:0] Q20Half = 32'h0008_0000;

   // func codes
   localparam logic FUNC_STEP = 1'b0;
   localparam logic FUNC_INIT = 1'b1;

   // run phase codes
   localparam logic [PhaseWidth-1:0] PHASE_IDLE     = 3'd0;
   localparam logic [PhaseWidth-1:0] PHASE_LEAVING  = 3'd1;
   localparam logic [PhaseWidth-1:0] PHASE_RUNNING  = 3'd2;
   localparam logic [PhaseWidth-1:0] PHASE_APPROACH = 3'd3;
   localparam logic [PhaseWidth-1:0] PHASE_FINISHED = 3'd4;

   // register indexes
   localparam logic [IndexWidth-1:0] REG_LEFT_SCALE  = 2'd0;
   localparam logic [IndexWidth-1:0] REG_RIGHT_SCALE = 2'd1;
   localparam logic [IndexWidth-1:0] REG_LEFT_CLAMP  = 2'd2;
   localparam logic [IndexWidth-1:0] REG_RIGHT_CLAMP = 2'd3;

   localparam logic [ScaleWidth-1:0] ScaleReset = 30'd1048576;
   localparam logic [TotalWidth-1:0] ClampReset = 32'd4095;

   // stage advance strobes shared by both wheel lanes
   typedef struct packed {
      logic load_clamp;
      logic load_mult;
   } pipe_ctrl_type;

   function automatic logic phase_running(input logic [PhaseWidth-1:0] ph);
      return (ph == PHASE_LEAVING) || (ph == PHASE_RUNNING) || (ph == PHASE_APPROACH);
   endfunction

endpackage

FILE: src/wolp_wheel.sv
`timescale 1ns / 1ps

module wolp_wheel (
   input  logic                                clock,
   input  wolp_pkg::pipe_ctrl_type             ctrl,
   input  logic [wolp_pkg::TotalWidth-1:0]     count,
   input  logic [wolp_pkg::ScaleWidth-1:0]     scale,
   input  logic [wolp_pkg::TotalWidth-1:0]     clamp,
   output logic [wolp_pkg::WheelWidth-1:0]     progress
);
   import wolp_pkg::*;

   logic [TotalWidth-1:0] clamped_ff;
   logic [TotalWidth-1:0] clamped_in;
   logic [TotalWidth-1:0] prod_ff;
   logic [TotalWidth-1:0] prod_in;
   logic [TotalWidth-1:0] rounded;

   assign clamped_in = (count > clamp) ? clamp : count;
   // only the low 32 bits of the product are kept
   assign prod_in    = TotalWidth'(clamped_ff * {{(TotalWidth-ScaleWidth){1'b0}}, scale});

   always_ff @(posedge clock) begin
      if (ctrl.load_clamp) begin
         clamped_ff <= clamped_in;
      end
      if (ctrl.load_mult) begin
         prod_ff <= prod_in;
      end
   end

   assign rounded  = prod_ff + Q20Half;
   assign progress = rounded[TotalWidth-1:Q20Shift];

endmodule

FILE: src/wheel_odometer_lap_progress.sv
`timescale 1ns / 1ps

// wheel odometer lap progress
//
// req channel: one item per control tick (func, run_phase and the two
// encoder totals). func init captures the zero offsets; a control step
// tracks, recaptures on a fresh start, or freezes on finish.
// rsp channel: one item per request, carrying averaged lap progress in
// tenths of a percent, the valid and frozen flags and both relative counts.
// csr channel: index 0..3 selects left/right scale and left/right clamp;
// always ready, write only while no item is in flight.
//
// order: the result shows on rsp_valid once the request has passed the
// state update, clamp, multiply, then round/average into the output
// register. throughput: one item per cycle while rsp is not held; the
// tracking state is updated in the accept cycle so the next tick sees it at once.
// stall: a held rsp backs up the four stages, each stage fills before
// req_ready drops, so nothing is lost or repeated.
// reset: counts, offsets, flags and pipe valids clear, scales go to 1.0
// per count in Q20 and clamps to 4095.

module wheel_odometer_lap_progress (
   input  logic                                 clock,
   input  logic                                 reset,
   // request items
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_func,
   input  logic [wolp_pkg::PhaseWidth-1:0]      req_run_phase,
   input  logic signed [wolp_pkg::TotalWidth-1:0] req_left_total,
   input  logic signed [wolp_pkg::TotalWidth-1:0] req_right_total,
   // result items
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [wolp_pkg::TenthsWidth-1:0]     rsp_lap_tenths,
   output logic                                 rsp_progress_valid,
   output logic                                 rsp_is_frozen,
   output logic signed [wolp_pkg::TotalWidth-1:0] rsp_left_rel,
   output logic signed [wolp_pkg::TotalWidth-1:0] rsp_right_rel,
   // configuration writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [wolp_pkg::IndexWidth-1:0]      csr_index,
   input  logic [wolp_pkg::TotalWidth-1:0]      csr_wdata
);
   import wolp_pkg::*;

   // configuration registers
   logic [ScaleWidth-1:0] left_scale_ff;
   logic [ScaleWidth-1:0] right_scale_ff;
   logic [TotalWidth-1:0] left_clamp_ff;
   logic [TotalWidth-1:0] right_clamp_ff;

   // tracking state
   logic [TotalWidth-1:0] left_origin_ff,  left_origin_in;
   logic [TotalWidth-1:0] right_origin_ff, right_origin_in;
   logic [TotalWidth-1:0] left_count_ff,   left_count_in;
   logic [TotalWidth-1:0] right_count_ff,  right_count_in;
   logic [PhaseWidth-1:0] prior_phase_ff,  prior_phase_in;
   logic                  frozen_ff,       frozen_in;
   logic                  init_done_ff,    init_done_in;

   // pipe valids
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   logic out_valid_ff, out_valid_in;

   // pipe payload
   logic [TotalWidth-1:0] s1_left_ff, s1_right_ff;
   logic                  s1_frozen_ff, s1_init_ff;
   logic [TotalWidth-1:0] s2_left_ff, s2_right_ff;
   logic                  s2_frozen_ff, s2_ok_ff;
   logic [TotalWidth-1:0] s3_left_ff, s3_right_ff;
   logic                  s3_frozen_ff, s3_ok_ff;

   logic [TenthsWidth-1:0] out_tenths_ff, out_tenths_in;
   logic                   out_pvalid_ff;
   logic                   out_frozen_ff;
   logic [TotalWidth-1:0]  out_left_ff, out_right_ff;

   logic accept;
   logic load2, load3, load_out;
   pipe_ctrl_type pipe_ctrl;

   logic [WheelWidth-1:0] left_prog, right_prog;
   logic [WheelWidth-1:0] avg;

   // ---------------------------------------------------------------
   // handshake: each stage loads when empty or when it drains forward
   // ---------------------------------------------------------------
   assign load_out  = s3_valid_ff && (!out_valid_ff || rsp_ready);
   assign load3     = s2_valid_ff && (!s3_valid_ff || load_out);
   assign load2     = s1_valid_ff && (!s2_valid_ff || load3);
   assign req_ready = !s1_valid_ff || load2;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign s1_valid_in  = accept   ? 1'b1 : (load2 ? 1'b0 : s1_valid_ff);
   assign s2_valid_in  = load2    ? 1'b1 : (load3 ? 1'b0 : s2_valid_ff);
   assign s3_valid_in  = load3    ? 1'b1 : (load_out ? 1'b0 : s3_valid_ff);
   assign out_valid_in = load_out ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   // ---------------------------------------------------------------
   // tracking update, applied in the accept cycle
   // ---------------------------------------------------------------
   always_comb begin
      logic was_run;
      logic [TotalWidth-1:0] lt, rt;
      lt = req_left_total;
      rt = req_right_total;
      was_run = phase_running(prior_phase_ff);

      left_origin_in  = left_origin_ff;
      right_origin_in = right_origin_ff;
      left_count_in   = left_count_ff;
      right_count_in  = right_count_ff;
      prior_phase_in  = prior_phase_ff;
      frozen_in       = frozen_ff;
      init_done_in    = init_done_ff;

      if (req_func == FUNC_INIT) begin
         left_origin_in  = lt;
         right_origin_in = rt;
         left_count_in   = '0;
         right_count_in  = '0;
         prior_phase_in  = req_run_phase;
         frozen_in       = 1'b0;
         init_done_in    = 1'b1;
      end else if (init_done_ff) begin
         // fresh start: recapture zeros, tracking follows on this tick
         if (req_run_phase == PHASE_LEAVING && !was_run) begin
            left_origin_in  = lt;
            right_origin_in = rt;
            left_count_in   = '0;
            right_count_in  = '0;
            frozen_in       = 1'b0;
         end
         if (phase_running(req_run_phase) && !frozen_in) begin
            left_count_in  = lt - left_origin_in;
            right_count_in = rt - right_origin_in;
         end else if (req_run_phase == PHASE_FINISHED && was_run && !frozen_in) begin
            left_count_in  = lt - left_origin_in;
            right_count_in = rt - right_origin_in;
            frozen_in      = 1'b1;
         end else if (req_run_phase == PHASE_IDLE && !frozen_in) begin
            left_count_in  = lt - left_origin_in;
            right_count_in = rt - right_origin_in;
         end
         prior_phase_in = req_run_phase;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_origin_ff  <= '0;
         right_origin_ff <= '0;
         left_count_ff   <= '0;
         right_count_ff  <= '0;
         prior_phase_ff  <= PHASE_IDLE;
         frozen_ff       <= 1'b0;
         init_done_ff    <= 1'b0;
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         s3_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         left_scale_ff   <= ScaleReset;
         right_scale_ff  <= ScaleReset;
         left_clamp_ff   <= ClampReset;
         right_clamp_ff  <= ClampReset;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         out_valid_ff <= out_valid_in;
         if (accept) begin
            left_origin_ff  <= left_origin_in;
            right_origin_ff <= right_origin_in;
            left_count_ff   <= left_count_in;
            right_count_ff  <= right_count_in;
            prior_phase_ff  <= prior_phase_in;
            frozen_ff       <= frozen_in;
            init_done_ff    <= init_done_in;
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_LEFT_SCALE:  left_scale_ff  <= csr_wdata[ScaleWidth-1:0];
               REG_RIGHT_SCALE: right_scale_ff <= csr_wdata[ScaleWidth-1:0];
               REG_LEFT_CLAMP:  left_clamp_ff  <= csr_wdata;
               REG_RIGHT_CLAMP: right_clamp_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------
   // progress pipe: snapshot, clamp, multiply, round and average
   // ---------------------------------------------------------------
   assign pipe_ctrl.load_clamp = load2;
   assign pipe_ctrl.load_mult  = load3;

   wolp_wheel u_left (
      .clock    (clock),
      .ctrl     (pipe_ctrl),
      .count    (s1_left_ff),
      .scale    (left_scale_ff),
      .clamp    (left_clamp_ff),
      .progress (left_prog)
   );

   wolp_wheel u_right (
      .clock    (clock),
      .ctrl     (pipe_ctrl),
      .count    (s1_right_ff),
      .scale    (right_scale_ff),
      .clamp    (right_clamp_ff),
      .progress (right_prog)
   );

   // carry rule average; two 12-bit halves never pass 4095
   assign avg = (left_prog >> 1) + (right_prog >> 1)
              + {{(WheelWidth-1){1'b0}}, left_prog[0] & right_prog[0]};
   assign out_tenths_in = s3_ok_ff ? {{(TenthsWidth-WheelWidth){1'b0}}, avg} : '0;

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_left_ff   <= left_count_in;
         s1_right_ff  <= right_count_in;
         s1_frozen_ff <= frozen_in;
         s1_init_ff   <= init_done_in;
      end
      if (load2) begin
         s2_left_ff   <= s1_left_ff;
         s2_right_ff  <= s1_right_ff;
         s2_frozen_ff <= s1_frozen_ff;
         // before init the stored progress is still all zero
         s2_ok_ff     <= s1_init_ff && !s1_left_ff[TotalWidth-1] && !s1_right_ff[TotalWidth-1];
      end
      if (load3) begin
         s3_left_ff   <= s2_left_ff;
         s3_right_ff  <= s2_right_ff;
         s3_frozen_ff <= s2_frozen_ff;
         s3_ok_ff     <= s2_ok_ff;
      end
      if (load_out) begin
         out_tenths_ff <= out_tenths_in;
         out_pvalid_ff <= s3_ok_ff;
         out_frozen_ff <= s3_frozen_ff;
         out_left_ff   <= s3_left_ff;
         out_right_ff  <= s3_right_ff;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_lap_tenths     = out_tenths_ff;
   assign rsp_progress_valid = out_pvalid_ff;
   assign rsp_is_frozen      = out_frozen_ff;
   assign rsp_left_rel       = out_left_ff;
   assign rsp_right_rel      = out_right_ff;

endmodule
